### hw/rtl/iopp_pkg.sv
`default_nettype none
package iopp_pkg;

  localparam int unsigned MAX_PACKET_BYTES_DEF = 2048;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W        = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_IDLE    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_TYPE   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TYPE   = 8'd3;

  localparam logic [15:0] ADDR_TYPE_RST = 16'h8002;
  localparam logic [15:0] DATA_TYPE_RST = 16'h00B1;

  // result kinds
  localparam logic RES_PAYLOAD = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  localparam logic [10:0] SAT11 = 11'h7FF;

  // results per input beat and result queue sizing
  localparam int unsigned MAX_RES  = 4;
  localparam int unsigned RQ_DEPTH = 16;
  localparam int unsigned RQ_AW    = 4;
  localparam int unsigned RQ_CW    = 5;
  localparam int unsigned RQ_ROOM  = RQ_DEPTH - 2 * MAX_RES;

  typedef enum logic [2:0] {
    PH_COUNT_LO,
    PH_COUNT_HI,
    PH_HEADER,
    PH_BODY,
    PH_IDLE
  } phase_t;

  typedef enum logic [1:0] {
    ITEM_OTHER,
    ITEM_ADDR,
    ITEM_DATA
  } item_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [10:0] payload_offset;
    logic        data_found;
    logic [31:0] connection_id;
    logic [10:0] payload_length;
    logic [31:0] first_word;
    logic        accepted;
    logic        last;
  } out_beat_t;

  typedef struct packed {
    logic        run_idle_present;
    logic [31:0] expected_connection_id;
    logic [15:0] address_item_type;
    logic [15:0] data_item_type;
  } cfg_t;

  typedef struct packed {
    logic [2:0]                cnt;
    out_beat_t [MAX_RES-1:0]   beat;
  } push_t;

  function automatic logic [10:0] sat11(logic [15:0] v);
    return (v > 16'(SAT11)) ? SAT11 : v[10:0];
  endfunction

  function automatic out_beat_t mk_payload(logic [7:0] b, logic [15:0] off);
    out_beat_t r;
    r                = '0;
    r.kind           = RES_PAYLOAD;
    r.payload_byte   = b;
    r.payload_offset = sat11(off);
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/io_packet_item_parser_top.sv
`default_nettype none
// Streaming parser for received cyclic I/O packets in common packet format. One packet byte
// is taken per beat on the in_ channel; the beat with end_of_packet closes the packet. Each
// byte is registered, parsed in the following cycle and its results (payload bytes of the
// connected-data item with their offsets, and one summary per packet) are queued in a
// 16-entry result queue that drains one beat per cycle on the out_ channel while out_stall
// is low. Input runs at one beat per cycle while the queue has room; a byte that ends a short
// data item can release up to three held bytes and the final byte adds a summary, so one byte
// can push up to four result beats, and the input stalls only while the result queue holds
// more than eight beats. Bytes past MAX_PACKET_BYTES in a packet are dropped but the end mark
// is still honored. Configuration writes are always ready and take effect on the next byte.
module io_packet_item_parser_top #(
  parameter int unsigned MAX_PACKET_BYTES = iopp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire iopp_pkg::in_beat_t             in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output iopp_pkg::out_beat_t                 out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [iopp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import iopp_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  room;
  logic  in_take;

  assign in_stall = !room;
  assign in_take  = in_valid && room;

  iopp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  iopp_parse #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_take (in_take),
    .in_data (in_data),
    .cfg     (cfg),
    .push    (push)
  );

  iopp_rqueue u_rqueue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

### hw/rtl/iopp_cfg.sv
`default_nettype none
module iopp_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [iopp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data,
  output iopp_pkg::cfg_t                      cfg
);
  import iopp_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_idle_present       <= 1'b0;
      cfg_r.expected_connection_id <= '0;
      cfg_r.address_item_type      <= ADDR_TYPE_RST;
      cfg_r.data_item_type         <= DATA_TYPE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RUN_IDLE:    cfg_r.run_idle_present       <= cfg_data[0];
        CFG_EXPECTED_ID: cfg_r.expected_connection_id <= cfg_data;
        CFG_ADDR_TYPE:   cfg_r.address_item_type      <= cfg_data[15:0];
        CFG_DATA_TYPE:   cfg_r.data_item_type         <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### hw/rtl/iopp_parse.sv
`default_nettype none
module iopp_parse #(
  parameter int unsigned MAX_PACKET_BYTES = iopp_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_take,
  input  wire iopp_pkg::in_beat_t in_data,
  input  wire iopp_pkg::cfg_t     cfg,
  output iopp_pkg::push_t         push
);
  import iopp_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_PACKET_BYTES + 1);

  logic                 in_vld_r;
  in_beat_t             in_r;

  phase_t               phase_r, phase_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [15:0]          items_r, items_nxt;
  logic [1:0]           hdr_r, hdr_nxt;
  logic [15:0]          type_r, type_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic [15:0]          off_r, off_nxt;
  logic [5:0][7:0]      hold_r, hold_nxt;
  logic [31:0]          id_r, id_nxt;
  logic [31:0]          shift_r, shift_nxt;
  logic                 found_r, found_nxt;
  logic [10:0]          len_r, len_nxt;
  logic [31:0]          word_r, word_nxt;
  item_kind_t           kind_r, kind_nxt;

  logic [7:0]           b;
  logic                 eop;
  logic [15:0]          strip;
  logic [15:0]          eoff;
  logic                 flush;
  logic [2:0]           n;
  out_beat_t [MAX_RES-1:0] res;
  out_beat_t            sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_take;
    end
    if (in_take) begin
      in_r <= in_data;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    items_nxt = items_r;
    hdr_nxt   = hdr_r;
    type_nxt  = type_r;
    rem_nxt   = rem_r;
    off_nxt   = off_r;
    hold_nxt  = hold_r;
    id_nxt    = id_r;
    shift_nxt = shift_r;
    found_nxt = found_r;
    len_nxt   = len_r;
    word_nxt  = word_r;
    kind_nxt  = kind_r;
    b         = in_r.data_byte;
    eop       = in_r.end_of_packet;
    strip     = cfg.run_idle_present ? 16'd6 : 16'd2;
    eoff      = off_r - strip;
    flush     = 1'b0;
    n         = '0;
    res       = '0;
    sum       = '0;
    if (in_vld_r) begin
      if (pos_r < POS_W'(MAX_PACKET_BYTES)) begin
        pos_nxt = pos_r + POS_W'(1);
        case (phase_r)
          PH_COUNT_LO: begin
            items_nxt = {8'h00, b};
            phase_nxt = PH_COUNT_HI;
          end
          PH_COUNT_HI: begin
            items_nxt = {b, items_r[7:0]};
            hdr_nxt   = 2'd0;
            phase_nxt = (items_nxt != 16'd0) ? PH_HEADER : PH_IDLE;
          end
          PH_HEADER: begin
            case (hdr_r)
              2'd0:    type_nxt = {8'h00, b};
              2'd1:    type_nxt = {b, type_r[7:0]};
              2'd2:    rem_nxt  = {8'h00, b};
              default: rem_nxt  = {b, rem_r[7:0]};
            endcase
            if (hdr_r == 2'd3) begin
              // header complete: classify and open the item
              hdr_nxt   = 2'd0;
              items_nxt = items_r - 16'd1;
              off_nxt   = 16'd0;
              if (type_r == cfg.address_item_type && rem_nxt >= 16'd8) begin
                kind_nxt  = ITEM_ADDR;
                shift_nxt = '0;
              end else if (type_r == cfg.data_item_type) begin
                kind_nxt  = ITEM_DATA;
                found_nxt = 1'b1;
                len_nxt   = '0;
                word_nxt  = '0;
              end else begin
                kind_nxt = ITEM_OTHER;
              end
              phase_nxt = PH_BODY;
              if (rem_nxt == 16'd0) begin
                phase_nxt = (items_nxt != 16'd0) ? PH_HEADER : PH_IDLE;
              end
            end else begin
              hdr_nxt = hdr_r + 2'd1;
            end
          end
          PH_BODY: begin
            case (kind_r)
              ITEM_ADDR: begin
                if (off_r < 16'd4) begin
                  shift_nxt = shift_r | ({24'h0, b} << {off_r[1:0], 3'b000});
                end
                if (off_r == 16'd7) begin
                  id_nxt = shift_r;
                end
              end
              ITEM_DATA: begin
                if (off_r < strip) begin
                  if (off_r < 16'd6) begin
                    hold_nxt[off_r[2:0]] = b;
                  end
                end else begin
                  res[0] = mk_payload(b, eoff);
                  n      = 3'd1;
                  if (eoff < 16'd4) begin
                    word_nxt = word_r | ({24'h0, b} << {eoff[1:0], 3'b000});
                  end
                  len_nxt = sat11(eoff + 16'd1);
                end
              end
              default: ;
            endcase
            off_nxt = off_r + 16'd1;
            rem_nxt = rem_r - 16'd1;
            if (rem_nxt == 16'd0) begin
              hdr_nxt   = 2'd0;
              phase_nxt = (items_r != 16'd0) ? PH_HEADER : PH_IDLE;
              flush     = (kind_r == ITEM_DATA);
            end
          end
          default: ;
        endcase
      end

      // packet cut short inside a data item
      if (eop && phase_nxt == PH_BODY && kind_nxt == ITEM_DATA) begin
        flush = 1'b1;
      end

      // held bytes of a data item that ended before its header was stripped
      if (flush && off_nxt < strip) begin
        if (off_nxt < 16'd2) begin
          if (off_nxt[0]) begin
            res[0]   = mk_payload(hold_nxt[0], 16'd0);
            n        = 3'd1;
            word_nxt = word_nxt | {24'h0, hold_nxt[0]};
            len_nxt  = 11'd1;
          end
        end else begin
          for (int i = 0; i < 3; i++) begin
            if (16'(i + 2) < off_nxt) begin
              res[i]   = mk_payload(hold_nxt[i + 2], 16'(i));
              word_nxt = word_nxt | ({24'h0, hold_nxt[i + 2]} << (8 * i));
              len_nxt  = 11'(i + 1);
              n        = 3'(i + 1);
            end
          end
        end
      end

      if (eop) begin
        sum.kind           = RES_SUMMARY;
        sum.data_found     = found_nxt;
        sum.connection_id  = id_nxt;
        sum.payload_length = len_nxt;
        sum.first_word     = (len_nxt >= 11'd4) ? word_nxt : '0;
        sum.accepted       = found_nxt && (id_nxt == cfg.expected_connection_id);
        res[n[1:0]]        = sum;
        n                  = n + 3'd1;
        phase_nxt = PH_COUNT_LO;
        pos_nxt   = '0;
        items_nxt = '0;
        hdr_nxt   = '0;
        type_nxt  = '0;
        rem_nxt   = '0;
        off_nxt   = '0;
        id_nxt    = '0;
        shift_nxt = '0;
        found_nxt = 1'b0;
        len_nxt   = '0;
        word_nxt  = '0;
        kind_nxt  = ITEM_OTHER;
      end

      if (n != 3'd0) begin
        res[2'(n - 3'd1)].last = 1'b1;
      end
    end
  end

  assign push.cnt  = n;
  assign push.beat = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_COUNT_LO;
      pos_r   <= '0;
      items_r <= '0;
      hdr_r   <= '0;
      type_r  <= '0;
      rem_r   <= '0;
      off_r   <= '0;
      id_r    <= '0;
      shift_r <= '0;
      found_r <= 1'b0;
      len_r   <= '0;
      word_r  <= '0;
      kind_r  <= ITEM_OTHER;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      items_r <= items_nxt;
      hdr_r   <= hdr_nxt;
      type_r  <= type_nxt;
      rem_r   <= rem_nxt;
      off_r   <= off_nxt;
      id_r    <= id_nxt;
      shift_r <= shift_nxt;
      found_r <= found_nxt;
      len_r   <= len_nxt;
      word_r  <= word_nxt;
      kind_r  <= kind_nxt;
    end
    hold_r <= hold_nxt;
  end

endmodule
`default_nettype wire

### hw/rtl/iopp_rqueue.sv
`default_nettype none
module iopp_rqueue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire iopp_pkg::push_t     push,
  output logic                     room,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output iopp_pkg::out_beat_t      out_data
);
  import iopp_pkg::*;

  out_beat_t              mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0]       wr_r, wr_nxt;
  logic [RQ_AW-1:0]       rd_r, rd_nxt;
  logic [RQ_CW-1:0]       cnt_r, cnt_nxt;
  logic                   pop;

  // room for the results of the input beat in flight plus one more
  assign room      = (cnt_r <= RQ_CW'(RQ_ROOM));
  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_nxt  = wr_r + RQ_AW'(push.cnt);
    rd_nxt  = rd_r + RQ_AW'(pop);
    cnt_nxt = cnt_r + RQ_CW'(push.cnt) - RQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (3'(i) < push.cnt) begin
        mem_r[wr_r + RQ_AW'(i)] <= push.beat[i];
      end
    end
  end

endmodule
`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import iopp_pkg::*;

  localparam int unsigned HOLD_CYCLES    = 120;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DIR_ROWS       = 26;
  localparam int unsigned PRESS_BYTES    = 64;

  // directed row flags: {typed zero summary, end of packet}
  localparam logic [1:0] ROW_MID      = 2'b00;
  localparam logic [1:0] ROW_EOP      = 2'b01;
  localparam logic [1:0] ROW_EOP_ZERO = 2'b11;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_beat_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_beat_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data  = '0;

  io_packet_item_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // parser settings as written through the config port
  logic        ri_hdr    = 1'b0;
  logic [31:0] want_id   = '0;
  logic [15:0] addr_code = ADDR_TYPE_RST;
  logic [15:0] data_code = DATA_TYPE_RST;

  // per-packet parse state
  phase_t      st_phase;
  item_kind_t  cur_kind;
  int unsigned byte_count;
  logic [15:0] items_todo;
  logic [1:0]  hdr_pos;
  logic [15:0] item_code;
  logic [15:0] item_left;
  logic [15:0] item_pos;
  logic [7:0]  lead_bytes [6];
  logic [31:0] conn_id;
  logic [31:0] id_acc;
  logic        seen_data;
  logic [10:0] pay_len;
  logic [31:0] pay_word;

  out_beat_t   step_res[$];
  out_beat_t   pending_beats[$];
  logic [7:0]  pkt[$];
  logic [9:0]  dir_rows [DIR_ROWS];

  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_cnt     = 0;
  bit          hold_armed   = 1'b0;
  bit          calm         = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned strip_len();
    return ri_hdr ? 6 : 2;
  endfunction

  function automatic void restart_packet();
    st_phase   = PH_COUNT_LO;
    cur_kind   = ITEM_OTHER;
    byte_count = 0;
    items_todo = '0;
    hdr_pos    = '0;
    item_code  = '0;
    item_left  = '0;
    item_pos   = '0;
    conn_id    = '0;
    id_acc     = '0;
    seen_data  = 1'b0;
    pay_len    = '0;
    pay_word   = '0;
  endfunction

  function automatic void emit_byte(logic [7:0] b, int unsigned off);
    out_beat_t r;
    r                = '0;
    r.kind           = RES_PAYLOAD;
    r.payload_byte   = b;
    r.payload_offset = (off > SAT11) ? SAT11 : 11'(off);
    if (off < 4) pay_word = pay_word | (32'(b) << (8 * off));
    pay_len = (off + 1 > SAT11) ? SAT11 : 11'(off + 1);
    step_res.push_back(r);
  endfunction

  // data item ended before its sequence count / run-idle header was dropped
  function automatic void release_lead();
    int unsigned i;
    if (item_pos >= strip_len()) return;
    if (item_pos < 2) begin
      for (i = 0; i < item_pos; i++) emit_byte(lead_bytes[i], i);
    end else begin
      for (i = 2; i < item_pos && i < 6; i++) emit_byte(lead_bytes[i], i - 2);
    end
  endfunction

  function automatic void close_item();
    if (cur_kind == ITEM_DATA) release_lead();
    hdr_pos = '0;
    if (items_todo != 0) st_phase = PH_HEADER;
    else st_phase = PH_IDLE;
  endfunction

  function automatic void open_item();
    items_todo = items_todo - 1'b1;
    item_pos   = '0;
    if (item_code == addr_code && item_left >= 8) begin
      cur_kind = ITEM_ADDR;
      id_acc   = '0;
    end else if (item_code == data_code) begin
      cur_kind  = ITEM_DATA;
      seen_data = 1'b1;
      pay_len   = '0;
      pay_word  = '0;
    end else begin
      cur_kind = ITEM_OTHER;
    end
    st_phase = PH_BODY;
    if (item_left == 0) close_item();
  endfunction

  function automatic void item_byte(logic [7:0] b);
    int unsigned k;
    k = item_pos;
    if (cur_kind == ITEM_ADDR) begin
      if (k < 4) id_acc = id_acc | (32'(b) << (8 * k));
      if (k == 7) conn_id = id_acc;
    end else if (cur_kind == ITEM_DATA) begin
      if (k < strip_len()) begin
        if (k < 6) lead_bytes[k] = b;
      end else begin
        emit_byte(b, k - strip_len());
      end
    end
    item_pos  = item_pos + 1'b1;
    item_left = item_left - 1'b1;
    if (item_left == 0) close_item();
  endfunction

  // results caused by one packet byte, left in step_res
  function automatic void parse_byte(logic [7:0] b, logic eop);
    out_beat_t r;
    step_res.delete();
    if (byte_count < MAX_PACKET_BYTES_DEF) begin
      byte_count++;
      case (st_phase)
        PH_COUNT_LO: begin
          items_todo = {8'h00, b};
          st_phase   = PH_COUNT_HI;
        end
        PH_COUNT_HI: begin
          items_todo[15:8] = b;
          hdr_pos          = '0;
          if (items_todo != 0) st_phase = PH_HEADER;
          else st_phase = PH_IDLE;
        end
        PH_HEADER: begin
          case (hdr_pos)
            2'd0: item_code = {8'h00, b};
            2'd1: item_code[15:8] = b;
            2'd2: item_left = {8'h00, b};
            default: item_left[15:8] = b;
          endcase
          if (hdr_pos == 2'd3) begin
            hdr_pos = '0;
            open_item();
          end else begin
            hdr_pos = hdr_pos + 1'b1;
          end
        end
        PH_BODY: item_byte(b);
        default: ;
      endcase
    end
    if (eop) begin
      if (st_phase == PH_BODY && cur_kind == ITEM_DATA) release_lead();
      r                = '0;
      r.kind           = RES_SUMMARY;
      r.data_found     = seen_data;
      r.connection_id  = conn_id;
      r.payload_length = pay_len;
      r.first_word     = (pay_len >= 4) ? pay_word : '0;
      r.accepted       = seen_data && (conn_id == want_id);
      step_res.push_back(r);
      restart_packet();
    end
    if (step_res.size() != 0) begin
      r      = step_res.pop_back();
      r.last = 1'b1;
      step_res.push_back(r);
    end
  endfunction

  function automatic void build_packet();
    int unsigned n_items, cnt, pick, dlen, len, i, j, cut;
    logic [15:0] ty;
    logic [31:0] id;
    pkt.delete();
    if ($urandom_range(0, 99) < 8) begin
      len = $urandom_range(1, 12);
      repeat (len) pkt.push_back(8'($urandom));
      return;
    end
    n_items = $urandom_range(0, 4);
    cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : n_items;
    pkt.push_back(8'(cnt));
    pkt.push_back(8'(cnt >> 8));
    for (i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        ty   = addr_code;
        dlen = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 12);
      end else if (pick < 8) begin
        ty   = data_code;
        dlen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 24);
      end else begin
        ty   = 16'($urandom);
        dlen = $urandom_range(0, 10);
      end
      // declared length past the bytes that follow
      if ($urandom_range(0, 19) == 0) dlen = $urandom_range(0, 65535);
      len = (dlen > 30) ? $urandom_range(0, 30) : dlen;
      id  = $urandom_range(0, 1) ? want_id : $urandom;
      pkt.push_back(ty[7:0]);
      pkt.push_back(ty[15:8]);
      pkt.push_back(8'(dlen));
      pkt.push_back(8'(dlen >> 8));
      for (j = 0; j < len; j++)
        pkt.push_back((ty == addr_code && j < 4) ? id[8*j +: 8] : 8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
    if ($urandom_range(0, 9) == 0 && pkt.size() > 1) begin
      cut = $urandom_range(1, pkt.size() - 1);
      while (pkt.size() > cut) void'(pkt.pop_back());
    end
  endfunction

  task automatic send_byte(logic [7:0] b, logic eop, bit zero_summary);
    out_beat_t r;
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {b, eop};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parse_byte(b, eop);
    if (zero_summary) begin
      step_res.delete();
      r      = '0;
      r.kind = RES_SUMMARY;
      r.last = 1'b1;
      step_res.push_back(r);
    end
    foreach (step_res[i]) pending_beats.push_back(step_res[i]);
  endtask

  task automatic send_span(int unsigned lo, int unsigned hi);
    int unsigned i;
    for (i = lo; i < hi; i++) send_byte(pkt[i], i == pkt.size() - 1, 1'b0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_beat(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_RUN_IDLE:    ri_hdr = val[0];
      CFG_EXPECTED_ID: want_id = val;
      CFG_ADDR_TYPE:   addr_code = val[15:0];
      default:         data_code = val[15:0];
    endcase
  endtask

  task automatic write_cfg(logic ri, logic [31:0] id, logic [15:0] at, logic [15:0] dt);
    cfg_beat(CFG_RUN_IDLE, {31'b0, ri});
    cfg_beat(CFG_EXPECTED_ID, id);
    cfg_beat(CFG_ADDR_TYPE, {16'b0, at});
    cfg_beat(CFG_DATA_TYPE, {16'b0, dt});
    cfg_valid <= 1'b0;
  endtask

  function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result beat: expected none, actual %h", $time, out_data);
      end else begin
        want = pending_beats.pop_front();
        field_check("kind", want.kind, out_data.kind);
        field_check("payload_byte", want.payload_byte, out_data.payload_byte);
        field_check("payload_offset", want.payload_offset, out_data.payload_offset);
        field_check("data_found", want.data_found, out_data.data_found);
        field_check("connection_id", want.connection_id, out_data.connection_id);
        field_check("payload_length", want.payload_length, out_data.payload_length);
        field_check("first_word", want.first_word, out_data.first_word);
        field_check("accepted", want.accepted, out_data.accepted);
        field_check("last", want.last, out_data.last);
      end
    end
  end

  // receiver: one long hold-off once armed, random stalls otherwise
  always @(posedge clk) begin
    if (hold_armed && hold_cnt < HOLD_CYCLES) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 6);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("io_packet_item_parser_top verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned i, ph, sent, split, budget;
    restart_packet();
    dir_rows = '{
      {ROW_EOP_ZERO, 8'hFF},                         // count cut short by end mark
      {ROW_MID, 8'h00}, {ROW_MID, 8'h00},            // zero items, trailing bytes ignored
      {ROW_MID, 8'hFF}, {ROW_EOP_ZERO, 8'h55},
      {ROW_MID, 8'h02}, {ROW_MID, 8'h00},            // two items
      {ROW_MID, 8'h02}, {ROW_MID, 8'h80},            // address item, 8 bytes
      {ROW_MID, 8'h08}, {ROW_MID, 8'h00},
      {ROW_MID, 8'h78}, {ROW_MID, 8'h56}, {ROW_MID, 8'h34}, {ROW_MID, 8'h12},
      {ROW_MID, 8'hFF}, {ROW_MID, 8'hFF}, {ROW_MID, 8'hFF}, {ROW_MID, 8'hFF},
      {ROW_MID, 8'hB1}, {ROW_MID, 8'h00},            // data item, 3 bytes
      {ROW_MID, 8'h03}, {ROW_MID, 8'h00},
      {ROW_MID, 8'h01}, {ROW_MID, 8'h00}, {ROW_EOP, 8'hFF}
    };
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++) send_byte(dir_rows[i][7:0], dir_rows[i][8], dir_rows[i][9]);

    // one long data item while the receiver holds off
    pkt.delete();
    pkt = '{8'h01, 8'h00, DATA_TYPE_RST[7:0], DATA_TYPE_RST[15:8], 8'(PRESS_BYTES), 8'h00};
    while (pkt.size() < PRESS_BYTES + 6) pkt.push_back(8'($urandom));
    hold_armed = 1'b1;
    send_span(0, pkt.size());

    for (ph = 0; ph < 6; ph++) begin
      // first packet of each setting changes registers between its beats
      build_packet();
      split = (pkt.size() > 1) ? $urandom_range(1, pkt.size() - 1) : pkt.size();
      send_span(0, split);
      drain();
      case (ph)
        0: write_cfg(1'b1, 32'h12345678, ADDR_TYPE_RST, DATA_TYPE_RST);
        1: write_cfg(1'b0, 32'hFFFFFFFF, 16'hFFFF, 16'h0000);
        2: write_cfg(1'b1, $urandom, 16'h00B1, 16'h00B1);
        3: write_cfg(1'b0, 32'h00000000, 16'h0000, 16'hFFFF);
        4: write_cfg(1'b1, $urandom, 16'($urandom), 16'($urandom));
        default: write_cfg(1'b0, 32'hFFFFFFFF, ADDR_TYPE_RST, DATA_TYPE_RST);
      endcase
      calm = (ph == 2);
      send_span(split, pkt.size());
      budget = calm ? 60 : 0;
      sent   = 0;
      while (sent < budget) begin
        build_packet();
        send_span(0, pkt.size());
        sent += pkt.size();
      end
    end
    calm = 1'b0;

    drain();
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("io_packet_item_parser_top verification clean");
    end else begin
      $display("io_packet_item_parser_top verification failed");
    end
    $finish;
  end

endmodule
